FILE: hdl/ple_pkg.sv
// Shared constants, codes and control types for the positional list engine.
package ple_pkg;

  localparam int CAPACITY_DEF    = 128;
  localparam int ENTRY_WIDTH_DEF = 16;
  // Cells examined per cycle by the scan unit.
  localparam int SCAN_GROUP      = 32;

  localparam int OPC_W     = 3;
  localparam int VAL_W     = 16;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 8;

  localparam logic [OPC_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OPC_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OPC_W-1:0] OP_INS_POS   = 3'd2;
  localparam logic [OPC_W-1:0] OP_REM_FRONT = 3'd3;
  localparam logic [OPC_W-1:0] OP_REM_END   = 3'd4;
  localparam logic [OPC_W-1:0] OP_REM_POS   = 3'd5;
  localparam logic [OPC_W-1:0] OP_SEARCH    = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  // Returned by the scan unit.
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

FILE: hdl/ple_if.sv
// Valid/ready channel interfaces for list commands and list results.
interface ple_in_if import ple_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [VAL_W-1:0] item_value;
  logic [POS_W-1:0] position;

  modport source (output valid, output opcode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input position,
                  output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     removed_value;
  logic                 found;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, output removed_value, output found, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input removed_value, input found, input status,
                  input entry_count, output ready);
endinterface

FILE: hdl/ple_cell.sv
// One list slot: holds an entry, shifts with its neighbors, matches the search key.
module ple_cell import ple_pkg::*; #(
  parameter int IDX   = 0,
  parameter int EW    = ENTRY_WIDTH_DEF,
  parameter int IDX_W = 7,
  parameter int CNT_W = 8
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] pos,
  input  logic [EW-1:0]    ins_data,
  input  logic [EW-1:0]    key,
  input  logic [CNT_W-1:0] count,
  input  logic [EW-1:0]    left_i,
  input  logic [EW-1:0]    right_i,
  output logic [EW-1:0]    data_o,
  output logic             hit_o,
  output logic [EW-1:0]    tap_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

  logic [EW-1:0] data_r;
  logic [EW-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX == pos) begin
        data_nxt = ins_data;
      end else if (MY_IDX > pos) begin
        data_nxt = left_i;
      end
    end else if (ctl.rem && (MY_IDX >= pos)) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // only live slots may match
  assign hit_o  = (data_r == key) && (MY_CNT < count);
  assign tap_o  = (MY_IDX == pos) ? data_r : '0;

endmodule

FILE: hdl/ple_scan.sv
// Group-at-a-time scan over the cell row: ORs match flags and picks the tapped entry.
module ple_scan import ple_pkg::*; #(
  parameter int N  = CAPACITY_DEF,
  parameter int EW = ENTRY_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [N-1:0]    hit_vec,
  input  logic [N*EW-1:0] tap_vec,
  output scan_stat_t      stat_o,
  output logic [EW-1:0]   removed_o
);

  localparam int G       = SCAN_GROUP;
  localparam int STEPS   = (N + G - 1) / G;
  localparam int PAD     = STEPS * G;
  localparam int TAP_PAD = PAD * EW;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int SC_W    = $clog2(STEPS + 1);

  logic [SC_W-1:0]    step_r;
  logic               found_r;
  logic [EW-1:0]      tap_acc_r;
  logic [PAD-1:0]     hit_pad;
  logic [TAP_PAD-1:0] tap_pad;
  logic [STEP_W-1:0]  step_idx;
  logic               grp_hit;
  logic [EW-1:0]      grp_tap;
  logic               done;

  assign hit_pad  = PAD'(hit_vec);
  assign tap_pad  = TAP_PAD'(tap_vec);
  assign step_idx = step_r[STEP_W-1:0];
  assign done     = (step_r == SC_W'(STEPS));

  always_comb begin
    grp_hit = |hit_pad[step_idx*G +: G];
    grp_tap = '0;
    for (int j = 0; j < G; j++) begin
      grp_tap = grp_tap | tap_pad[(step_idx*G + j)*EW +: EW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= SC_W'(STEPS);
      found_r <= 1'b0;
    end else if (start) begin
      step_r    <= '0;
      found_r   <= 1'b0;
      tap_acc_r <= '0;
    end else if (!done) begin
      step_r    <= step_r + SC_W'(1);
      found_r   <= found_r | grp_hit;
      tap_acc_r <= tap_acc_r | grp_tap;
    end
  end

  assign stat_o.done  = done;
  assign stat_o.found = found_r;
  assign removed_o    = tap_acc_r;

endmodule

FILE: hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: command decode, cell row, scan and result register.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------------------
//  in_ch    | in  | valid/ready, transfer | opcode, item_value, position
//  out_ch   | out | valid/ready, transfer | removed_value, found, status, entry_count
//
// Flow: inserts, rejected operations and the unused opcode finish on their transfer and
//   may follow back to back. A search or a good remove holds off input while the scan
//   unit walks the cell row 32 slots per cycle, then loads the result register.
// Reset: synchronous, active low; clears the count and the control state. Entry slots
//   are not cleared; a slot is only read below the count.
// Stalls: the result register frees input as soon as out_ch takes its transfer.
module positional_list_engine_unit import ple_pkg::*; #(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  ple_in_if.sink   in_ch,
  ple_out_if.source out_ch
);

  localparam int EW    = ENTRY_WIDTH;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VPAD  = (EW > VAL_W) ? EW : VAL_W;
  localparam int CPAD  = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // held operands for the scan phase
  logic [EW-1:0]     key_r, key_nxt;
  logic [IDX_W-1:0]  pend_pos_r, pend_pos_nxt;
  logic              pend_rem_r, pend_rem_nxt;

  // result register
  logic [VAL_W-1:0]     out_rem_r, out_rem_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [STAT_W-1:0]    out_stat_r, out_stat_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // handshake
  logic in_ready;
  logic accept;
  logic out_free;

  // decode of the offered command
  logic [EW-1:0]     ins_val;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [IDX_W-1:0]  pos_lo;
  logic [IDX_W-1:0]  cnt_lo;
  logic [IDX_W-1:0]  last_lo;
  logic [CNT_W-1:0]  cnt_m1;
  logic              full;
  logic              empty;
  logic [STAT_W-1:0] stat_d;
  logic [IDX_W-1:0]  eff_pos_d;
  logic              do_ins_d;
  logic              do_scan_d;
  logic              rem_d;

  // cell row and scan
  cell_ctl_t           cell_ctl;
  logic [IDX_W-1:0]    cell_pos;
  logic [EW-1:0]       cell_data [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY*EW-1:0] tap_vec;
  logic                scan_start;
  scan_stat_t          scan_stat;
  logic [EW-1:0]       scan_removed;
  logic [VPAD-1:0]     val_pad;
  logic [VPAD-1:0]     rem_pad;
  logic [CPAD-1:0]     cnt_pad;

  assign val_pad = VPAD'(in_ch.item_value);
  assign ins_val = val_pad[EW-1:0];
  assign pos_c   = CMP_W'(in_ch.position);
  assign cnt_c   = CMP_W'(cnt_r);
  assign pos_lo  = pos_c[IDX_W-1:0];
  assign cnt_lo  = cnt_r[IDX_W-1:0];
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign last_lo = cnt_m1[IDX_W-1:0];
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign empty   = (cnt_r == '0);

  assign out_free = !out_valid_r || out_ch.ready;
  assign accept   = in_ch.valid && in_ready;

  // Command decode. Errors are settled here; only a search or a good remove scans.
  always_comb begin
    stat_d    = ST_OK;
    eff_pos_d = pos_lo;
    do_ins_d  = 1'b0;
    do_scan_d = 1'b0;
    rem_d     = 1'b0;
    case (in_ch.opcode)
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        if (in_ch.opcode == OP_INS_FRONT) begin
          eff_pos_d = '0;
        end else if (in_ch.opcode == OP_INS_END) begin
          eff_pos_d = cnt_lo;
        end
        if (full) begin
          stat_d = ST_FULL;
        end else if ((in_ch.opcode == OP_INS_POS) && (pos_c > cnt_c)) begin
          stat_d = ST_RANGE;
        end else begin
          do_ins_d = 1'b1;
        end
      end
      OP_REM_FRONT, OP_REM_END, OP_REM_POS: begin
        rem_d = 1'b1;
        if (in_ch.opcode == OP_REM_FRONT) begin
          eff_pos_d = '0;
        end else if (in_ch.opcode == OP_REM_END) begin
          eff_pos_d = last_lo;
        end
        if (empty) begin
          stat_d = ST_EMPTY;
        end else if ((in_ch.opcode == OP_REM_POS) && (pos_c >= cnt_c)) begin
          stat_d = ST_RANGE;
        end else begin
          do_scan_d = 1'b1;
        end
      end
      OP_SEARCH: begin
        do_scan_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: all other commands finish on the transfer; search and a good remove wait
  // for the scan, and a remove shifts the row in the cycle its result is loaded.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    pend_pos_nxt  = pend_pos_r;
    pend_rem_nxt  = pend_rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rem_nxt   = out_rem_r;
    out_found_nxt = out_found_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    cell_ctl      = '0;
    cell_pos      = eff_pos_d;
    scan_start    = 1'b0;
    in_ready      = 1'b0;
    rem_pad       = '0;
    cnt_pad       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = out_free;
        if (accept) begin
          if (do_scan_d) begin
            state_nxt    = S_SCAN;
            scan_start   = 1'b1;
            key_nxt      = ins_val;
            pend_pos_nxt = eff_pos_d;
            pend_rem_nxt = rem_d;
          end else begin
            cell_ctl.ins  = do_ins_d;
            if (do_ins_d) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            cnt_pad       = CPAD'(cnt_nxt);
            out_valid_nxt = 1'b1;
            out_rem_nxt   = '0;
            out_found_nxt = 1'b0;
            out_stat_nxt  = stat_d;
            out_cnt_nxt   = cnt_pad[CNT_OUT_W-1:0];
          end
        end
      end
      S_SCAN: begin
        cell_pos = pend_pos_r;
        if (scan_stat.done && out_free) begin
          state_nxt    = S_IDLE;
          cell_ctl.rem = pend_rem_r;
          if (pend_rem_r) begin
            cnt_nxt = cnt_m1;
            rem_pad = VPAD'(scan_removed);
          end
          cnt_pad       = CPAD'(cnt_nxt);
          out_valid_nxt = 1'b1;
          out_rem_nxt   = rem_pad[VAL_W-1:0];
          out_found_nxt = !pend_rem_r && scan_stat.found;
          out_stat_nxt  = ST_OK;
          out_cnt_nxt   = cnt_pad[CNT_OUT_W-1:0];
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    pend_pos_r  <= pend_pos_nxt;
    pend_rem_r  <= pend_rem_nxt;
    out_rem_r   <= out_rem_nxt;
    out_found_r <= out_found_nxt;
    out_stat_r  <= out_stat_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Cell row: slot 0 is the front; inserts pull from the left, removes from the right.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [EW-1:0] left_d;
    logic [EW-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = ins_val;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ple_cell #(
      .IDX   (g),
      .EW    (EW),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .pos      (cell_pos),
      .ins_data (ins_val),
      .key      (key_r),
      .count    (cnt_r),
      .left_i   (left_d),
      .right_i  (right_d),
      .data_o   (cell_data[g]),
      .hit_o    (hit_vec[g]),
      .tap_o    (tap_vec[g*EW +: EW])
    );
  end

  ple_scan #(
    .N  (CAPACITY),
    .EW (EW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .hit_vec   (hit_vec),
    .tap_vec   (tap_vec),
    .stat_o    (scan_stat),
    .removed_o (scan_removed)
  );

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_rem_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.status        = out_stat_r;
  assign out_ch.entry_count   = out_cnt_r;

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // list is frozen while a scan runs
  a_scan_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && !(scan_stat.done && out_free) |=> $stable(cnt_r))
    else $error("count moved during scan");

  // insert on a full list is refused with the full status
  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && ((in_ch.opcode == OP_INS_FRONT) || (in_ch.opcode == OP_INS_END) ||
    (in_ch.opcode == OP_INS_POS))
    |=> out_valid_r && (out_stat_r == ST_FULL) && $stable(cnt_r))
    else $error("insert into full list not refused");

  // finishing a remove drops the count by one
  a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && scan_stat.done && out_free && pend_rem_r
    |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("remove did not decrement count");

endmodule

FILE: tb/positional_list_engine_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional list engine: list commands checked against a list model.
module positional_list_engine_unit_tb import ple_pkg::*; ();

  // Opcode 7 has no function; the block must leave the list alone and still answer.
  localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the backpressure test
  localparam int STALL_LIMIT = 5000;  // cycles with no transfer on either channel
  localparam int TAIL_CYCLES = 16;    // covers the scan latency plus slack

  // One predicted response.
  typedef struct {
    logic [VAL_W-1:0]     removed_value;
    logic                 found;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] entry_count;
  } list_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ple_in_if  in_ch ();
  ple_out_if out_ch ();

  positional_list_engine_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // List model: front of the list is index 0.
  logic [VAL_W-1:0] stored_handles[$];
  // Responses predicted for accepted commands, oldest first.
  list_result_t     pending_results[$];

  int err_cnt        = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req_id    = 0;
  int quiet_cycles   = 0;
  bit offering       = 1'b0;  // our own copy of in_ch.valid as last driven

  // Applies one command to the list model and returns the response it should give.
  // Failed commands leave the list as it is; count is reported after the command.
  function automatic list_result_t predict_list_op(input logic [OPC_W-1:0] op,
                                                   input logic [VAL_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
    list_result_t r;
    int           idx;
    int           lvl;
    r   = '{removed_value: '0, found: 1'b0, status: ST_OK, entry_count: '0};
    idx = int'(pos);
    lvl = stored_handles.size();
    case (op)
      OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
        // full takes priority over a bad position
        if (lvl >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_INS_FRONT) idx = 0;
          else if (op == OP_INS_END) idx = lvl;
          if (idx > lvl) r.status = ST_RANGE;
          else stored_handles.insert(idx, val);
        end
      end
      OP_REM_FRONT, OP_REM_END, OP_REM_POS: begin
        // empty takes priority over a bad position
        if (lvl == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (op == OP_REM_FRONT) idx = 0;
          else if (op == OP_REM_END) idx = lvl - 1;
          if (idx >= lvl) begin
            r.status = ST_RANGE;
          end else begin
            r.removed_value = stored_handles[idx];
            stored_handles.delete(idx);
          end
        end
      end
      OP_SEARCH: begin
        foreach (stored_handles[i])
          if (stored_handles[i] == val) r.found = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = CNT_OUT_W'(stored_handles.size());
    return r;
  endfunction

  // Offers one command and returns at the edge where it transfers.
  // valid is left high so back-to-back commands need no extra NBA on it.
  task automatic send_list_op(input logic [OPC_W-1:0] op,
                              input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      if (offering) begin
        in_ch.valid <= 1'b0;
        offering = 1'b0;
      end
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= val;
    in_ch.position   <= pos;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_list_op(op, val, pos));
  endtask

  // Sender goes quiet until every outstanding response has come back.
  task automatic wait_results_drained();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Removes, searches, a bad insert position and the unused opcode on an empty list.
  task automatic test_empty_list();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_list_op(OP_REM_FRONT, 16'h0000, 8'd0);
    send_list_op(OP_REM_END,   16'hFFFF, 8'd0);
    send_list_op(OP_REM_POS,   16'h0000, 8'd0);
    send_list_op(OP_REM_POS,   16'hFFFF, 8'd255);  // empty reported before range
    send_list_op(OP_SEARCH,    16'h0000, 8'd0);    // nothing stored, no hit
    send_list_op(OP_INS_POS,   16'hA5A5, 8'd1);    // past the end
    send_list_op(OP_UNUSED,    16'hFFFF, 8'd255);
  endtask

  // Every opcode on a short list, including end-of-list positions and range errors.
  task automatic test_basic_ops();
    send_list_op(OP_INS_FRONT, 16'hFFFF, 8'd0);
    send_list_op(OP_INS_END,   16'h0000, 8'd0);
    send_list_op(OP_INS_POS,   16'h8001, 8'd1);    // middle
    send_list_op(OP_INS_POS,   16'h7FFE, 8'd3);    // position == count appends
    send_list_op(OP_INS_POS,   16'h1234, 8'd5);    // past the end
    send_list_op(OP_INS_POS,   16'h1234, 8'd128);
    send_list_op(OP_SEARCH,    16'hFFFF, 8'd0);    // hit at the front
    send_list_op(OP_SEARCH,    16'h1234, 8'd0);    // miss
    send_list_op(OP_SEARCH,    16'h7FFE, 8'd0);    // hit at the last entry
    send_list_op(OP_REM_POS,   16'h0000, 8'd4);    // position == count is out of range
    send_list_op(OP_REM_POS,   16'h0000, 8'd1);
    send_list_op(OP_REM_END,   16'h0000, 8'd0);
    send_list_op(OP_UNUSED,    16'h0000, 8'd0);
    send_list_op(OP_REM_FRONT, 16'h0000, 8'd0);
    send_list_op(OP_REM_POS,   16'hFFFF, 8'd0);    // last one out
    send_list_op(OP_SEARCH,    16'h0000, 8'd0);
  endtask

  // Fill to capacity, hit every full case, work at the last slot, then empty it again.
  task automatic test_full_list();
    logic [OPC_W-1:0] op;
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    while (stored_handles.size() < LIST_CAP) begin
      op = OPC_W'($urandom_range(OP_INS_FRONT, OP_INS_POS));
      send_list_op(op, 16'($urandom_range(16'hFFFF)),
                   8'($urandom_range(stored_handles.size())));
    end
    send_list_op(OP_INS_FRONT, 16'h5555, 8'd0);
    send_list_op(OP_INS_END,   16'hAAAA, 8'd0);
    send_list_op(OP_INS_POS,   16'h5555, 8'd0);
    send_list_op(OP_INS_POS,   16'hAAAA, 8'd200);  // full reported before range
    send_list_op(OP_SEARCH,    stored_handles[LIST_CAP-1], 8'd0);
    send_list_op(OP_REM_POS,   16'h0000, 8'd128);
    send_list_op(OP_REM_POS,   16'h0000, 8'd127);
    send_list_op(OP_INS_POS,   16'hC3C3, 8'd127);  // back to full via the last slot
    send_list_op(OP_REM_POS,   16'h0000, 8'd200);
    while (stored_handles.size() > 0) begin
      op = OPC_W'($urandom_range(OP_REM_FRONT, OP_REM_POS));
      send_list_op(op, 16'($urandom_range(16'hFFFF)),
                   8'($urandom_range(stored_handles.size() - 1)));
    end
    send_list_op(OP_REM_END, 16'h0000, 8'd0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so the
  // result register fills and the block has to stall its input.
  task automatic test_receiver_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_id++;
    repeat (24) begin
      send_list_op($urandom_range(1) ? OP_INS_END : OP_SEARCH,
                   16'($urandom_range(16'hFFFF)), 8'd0);
    end
    wait_results_drained();
  endtask

  // Random commands; list level wanders toward a target that changes every 25 commands.
  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    logic [OPC_W-1:0] op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] pos;
    int               target;
    int               lvl;
    int               ins_pct;
    int               r;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    target         = 0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 25 == 0) begin
        r = $urandom_range(3);
        target = (r == 0) ? 0 : (r == 1) ? LIST_CAP : $urandom_range(LIST_CAP);
      end
      lvl     = stored_handles.size();
      ins_pct = (lvl < target) ? 65 : 20;
      r       = $urandom_range(99);
      if (r < 3) op = OP_UNUSED;
      else if (r < 3 + ins_pct) op = OPC_W'($urandom_range(OP_INS_FRONT, OP_INS_POS));
      else if (r < 85) op = OPC_W'($urandom_range(OP_REM_FRONT, OP_REM_POS));
      else op = OP_SEARCH;
      val = VAL_W'($urandom_range(16'hFFFF));
      // searches mostly look for something that is there
      if (op == OP_SEARCH && lvl > 0 && $urandom_range(1))
        val = stored_handles[$urandom_range(lvl - 1)];
      // positions mostly near the valid window, sometimes anywhere in the field
      if ($urandom_range(9) < 8) pos = POS_W'($urandom_range(lvl + 1));
      else pos = POS_W'($urandom_range(255));
      send_list_op(op, val, pos);
    end
  endtask

  // Result side: random stalls, plus a counted hold-off when the test asks for one.
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_req_id != hold_seen) begin
      hold_seen = hold_req_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every result transfer against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: removed_value %0h found %0b status %0d entry_count %0d",
               out_ch.removed_value, out_ch.found, out_ch.status, out_ch.entry_count);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0h, got %0h", want.removed_value,
                 out_ch.removed_value);
          err_cnt++;
        end
        if (out_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_ch.found);
          err_cnt++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_ch.entry_count);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: no transfer on either channel for too long means the block hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_INS_FRONT;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_basic_ops();
    wait_results_drained();
    test_full_list();
    wait_results_drained();
    test_receiver_hold();
    // idle mixes: none, sender idle, receiver stalling, both
    test_random_traffic(25, 0, 0);
    test_random_traffic(25, 70, 0);
    test_random_traffic(25, 0, 70);
    test_random_traffic(25, 38, 38);

    wait_results_drained();
    // a late extra transfer would show up here as an unexpected result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: positional_list_engine_unit.f
hdl/ple_pkg.sv
hdl/ple_if.sv
hdl/ple_cell.sv
hdl/ple_scan.sv
hdl/positional_list_engine_unit.sv
tb/positional_list_engine_unit_tb.sv
